// ----- hw/rtl/gpr_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Glyph pixel rasterizer package
// Shared constants, the descriptor word passed from front to back, and the
// 5x7 font table.
// ----------------------------------------------------------------------------
package gpr_pkg;

    localparam int GLYPH_COLS = 5;
    localparam int GLYPH_ROWS = 7;
    localparam int PIX_N      = GLYPH_COLS * GLYPH_ROWS;
    localparam int IDX_W      = 6;

    typedef logic [PIX_N-1:0] pix_vec_t;

    typedef struct packed {
        logic [10:0] ox;
        logic [10:0] oy;
        logic [15:0] fg;
        logic [15:0] bg;
        pix_vec_t    glyph;
        pix_vec_t    mask;
    } desc_t;

    // Raw column bytes, column 0 in the top byte.
    function automatic logic [39:0] font_raw(input logic [7:0] code);
        logic [39:0] r;
        case (code)
            8'd33: r = 40'h00_00_5F_00_00;
            8'd34: r = 40'h00_07_00_07_00;
            8'd35: r = 40'h14_7F_14_7F_14;
            8'd36: r = 40'h24_2A_7F_2A_12;
            8'd37: r = 40'h23_13_08_64_62;
            8'd38: r = 40'h36_49_55_22_50;
            8'd39: r = 40'h00_05_03_00_00;
            8'd40: r = 40'h00_1C_22_41_00;
            8'd41: r = 40'h00_41_22_1C_00;
            8'd42: r = 40'h08_2A_1C_2A_08;
            8'd43: r = 40'h08_08_3E_08_08;
            8'd44: r = 40'h00_50_30_00_00;
            8'd45: r = 40'h08_08_08_08_08;
            8'd46: r = 40'h00_60_60_00_00;
            8'd47: r = 40'h20_10_08_04_02;
            8'd48: r = 40'h3E_51_49_45_3E;
            8'd49: r = 40'h00_42_7F_40_00;
            8'd50: r = 40'h42_61_51_49_46;
            8'd51: r = 40'h21_41_45_4B_31;
            8'd52: r = 40'h18_14_12_7F_10;
            8'd53: r = 40'h27_45_45_45_39;
            8'd54: r = 40'h3C_4A_49_49_30;
            8'd55: r = 40'h01_71_09_05_03;
            8'd56: r = 40'h36_49_49_49_36;
            8'd57: r = 40'h06_49_49_29_1E;
            8'd58: r = 40'h00_36_36_00_00;
            8'd59: r = 40'h00_56_36_00_00;
            8'd60: r = 40'h00_08_14_22_41;
            8'd61: r = 40'h14_14_14_14_14;
            8'd62: r = 40'h41_22_14_08_00;
            8'd63: r = 40'h02_01_51_09_06;
            8'd64: r = 40'h32_49_79_41_3E;
            8'd65: r = 40'h7E_11_11_11_7E;
            8'd66: r = 40'h7F_49_49_49_36;
            8'd67: r = 40'h3E_41_41_41_22;
            8'd68: r = 40'h7F_41_41_22_1C;
            8'd69: r = 40'h7F_49_49_49_41;
            8'd70: r = 40'h7F_09_09_01_01;
            8'd71: r = 40'h3E_41_41_51_32;
            8'd72: r = 40'h7F_08_08_08_7F;
            8'd73: r = 40'h00_41_7F_41_00;
            8'd74: r = 40'h20_40_41_3F_01;
            8'd75: r = 40'h7F_08_14_22_41;
            8'd76: r = 40'h7F_40_40_40_40;
            8'd77: r = 40'h7F_02_04_02_7F;
            8'd78: r = 40'h7F_04_08_10_7F;
            8'd79: r = 40'h3E_41_41_41_3E;
            8'd80: r = 40'h7F_09_09_09_06;
            8'd81: r = 40'h3E_41_51_21_5E;
            8'd82: r = 40'h7F_09_19_29_46;
            8'd83: r = 40'h46_49_49_49_31;
            8'd84: r = 40'h01_01_7F_01_01;
            8'd85: r = 40'h3F_40_40_40_3F;
            8'd86: r = 40'h1F_20_40_20_1F;
            8'd87: r = 40'h7F_20_18_20_7F;
            8'd88: r = 40'h63_14_08_14_63;
            8'd89: r = 40'h03_04_78_04_03;
            8'd90: r = 40'h61_51_49_45_43;
            default: r = 40'h0;
        endcase
        return r;
    endfunction

    // Glyph bits in column-major pixel order: bit col*7+row.
    function automatic pix_vec_t font_bits(input logic [7:0] code);
        logic [39:0] raw;
        pix_vec_t    b;
        raw = font_raw(code);
        for (int c = 0; c < GLYPH_COLS; c++) begin
            for (int r = 0; r < GLYPH_ROWS; r++) begin
                b[c*GLYPH_ROWS + r] = raw[(GLYPH_COLS-1-c)*8 + r];
            end
        end
        return b;
    endfunction

    function automatic logic [2:0] pos_col(input logic [IDX_W-1:0] idx);
        logic [2:0] c;
        if (idx >= 6'd28) begin
            c = 3'd4;
        end else if (idx >= 6'd21) begin
            c = 3'd3;
        end else if (idx >= 6'd14) begin
            c = 3'd2;
        end else if (idx >= 6'd7) begin
            c = 3'd1;
        end else begin
            c = 3'd0;
        end
        return c;
    endfunction

    function automatic logic [2:0] pos_row(input logic [IDX_W-1:0] idx);
        logic [IDX_W-1:0] base;
        logic [IDX_W-1:0] diff;
        base = IDX_W'(pos_col(idx)) * IDX_W'(GLYPH_ROWS);
        diff = idx - base;
        return diff[2:0];
    endfunction

endpackage

// ----- hw/rtl/gpr_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Glyph pixel rasterizer front end
// Registers one character request, looks up its glyph and builds the mask of
// pixels to emit, then queues a descriptor word unless the mask is empty.
// ----------------------------------------------------------------------------
module gpr_front #(
    parameter int SCREEN_W = 280,
    parameter int SCREEN_H = 240
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic signed [10:0] s_origin_x,
    input  logic signed [10:0] s_origin_y,
    input  logic [7:0]         s_char_code,
    input  logic [15:0]        s_fg_colour,
    input  logic [15:0]        s_bg_colour,
    output logic               push_valid,
    input  logic               push_ready,
    output gpr_pkg::desc_t     push_desc
);
    import gpr_pkg::*;

    localparam logic [11:0] W_LIM = 12'(SCREEN_W);
    localparam logic [11:0] H_LIM = 12'(SCREEN_H);

    logic        stage_valid_reg;
    logic [10:0] ox_reg;
    logic [10:0] oy_reg;
    logic [7:0]  code_reg;
    logic [15:0] fg_reg;
    logic [15:0] bg_reg;

    pix_vec_t              glyph;
    pix_vec_t              mask;
    logic [GLYPH_COLS-1:0] col_ok;
    logic [GLYPH_ROWS-1:0] row_ok;
    logic [11:0]           cx;
    logic [11:0]           ry;
    logic                  differ;
    logic                  consume;

    always_comb begin
        glyph  = font_bits(code_reg);
        differ = (fg_reg != bg_reg);
        cx     = '0;
        ry     = '0;
        for (int c = 0; c < GLYPH_COLS; c++) begin
            cx        = {ox_reg[10], ox_reg} + 12'(c);
            col_ok[c] = !cx[11] && (cx < W_LIM);
        end
        for (int r = 0; r < GLYPH_ROWS; r++) begin
            ry        = {oy_reg[10], oy_reg} + 12'(r);
            row_ok[r] = !ry[11] && (ry < H_LIM);
        end
        for (int c = 0; c < GLYPH_COLS; c++) begin
            for (int r = 0; r < GLYPH_ROWS; r++) begin
                mask[c*GLYPH_ROWS + r] = col_ok[c] && row_ok[r]
                                         && (glyph[c*GLYPH_ROWS + r] || differ);
            end
        end
    end

    assign push_valid = stage_valid_reg && (mask != '0);
    assign consume    = stage_valid_reg && ((mask == '0) || push_ready);
    assign s_ready    = !stage_valid_reg || consume;

    assign push_desc.ox    = ox_reg;
    assign push_desc.oy    = oy_reg;
    assign push_desc.fg    = fg_reg;
    assign push_desc.bg    = bg_reg;
    assign push_desc.glyph = glyph;
    assign push_desc.mask  = mask;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stage_valid_reg <= 1'b0;
        end else if (s_ready) begin
            stage_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            ox_reg   <= s_origin_x;
            oy_reg   <= s_origin_y;
            code_reg <= s_char_code;
            fg_reg   <= s_fg_colour;
            bg_reg   <= s_bg_colour;
        end
    end

endmodule

// ----- hw/rtl/gpr_fifo.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Glyph pixel rasterizer descriptor queue
// Two-entry queue of descriptor words between the front and back ends.
// ----------------------------------------------------------------------------
module gpr_fifo (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           in_valid,
    output logic           in_ready,
    input  gpr_pkg::desc_t in_desc,
    output logic           out_valid,
    input  logic           out_ready,
    output gpr_pkg::desc_t out_desc
);
    import gpr_pkg::*;

    localparam logic [1:0] DEPTH = 2'd2;

    desc_t      entry_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;
    logic [1:0] count_next;
    logic       push;
    logic       pop;

    assign in_ready  = (count_reg != DEPTH);
    assign out_valid = (count_reg != 2'd0);
    assign out_desc  = entry_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_comb begin
        count_next = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 2'd1;
        end else if (pop && !push) begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            count_reg <= count_next;
            if (push) begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop) begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= in_desc;
        end
    end

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= DEPTH)
        else $error("descriptor queue count exceeds its depth");

endmodule

// ----- hw/rtl/gpr_back.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Glyph pixel rasterizer back end
// Walks the emit mask of the current descriptor, one pixel word per cycle
// unless m_ready stalls it, and marks the word that clears the mask as last.
// ----------------------------------------------------------------------------
module gpr_back (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           pop_valid,
    output logic           pop_ready,
    input  gpr_pkg::desc_t pop_desc,
    output logic           m_valid,
    input  logic           m_ready,
    output logic [9:0]     m_pixel_x,
    output logic [9:0]     m_pixel_y,
    output logic [15:0]    m_pixel_colour,
    output logic           m_last_pixel
);
    import gpr_pkg::*;

    logic        active_reg;
    logic        active_next;
    desc_t       desc_reg;
    pix_vec_t    mask_next;
    logic        out_valid_reg;
    logic [9:0]  x_reg;
    logic [9:0]  y_reg;
    logic [15:0] colour_reg;
    logic        last_reg;

    logic [IDX_W-1:0] sel;
    logic [2:0]       col;
    logic [2:0]       row;
    pix_vec_t         rest;
    logic             adv;
    logic             load;
    logic [11:0]      px;
    logic [11:0]      py;

    always_comb begin
        sel = '0;
        for (int i = PIX_N - 1; i >= 0; i--) begin
            if (desc_reg.mask[i]) begin
                sel = IDX_W'(i);
            end
        end
    end

    assign col  = pos_col(sel);
    assign row  = pos_row(sel);
    assign rest = desc_reg.mask & (desc_reg.mask - PIX_N'(1));
    assign adv  = active_reg && (!out_valid_reg || m_ready);
    assign load = pop_valid && (!active_reg || (adv && (rest == '0)));
    assign px   = {desc_reg.ox[10], desc_reg.ox} + {9'd0, col};
    assign py   = {desc_reg.oy[10], desc_reg.oy} + {9'd0, row};

    assign pop_ready = load;

    always_comb begin
        active_next = active_reg;
        mask_next   = desc_reg.mask;
        if (load) begin
            active_next = 1'b1;
            mask_next   = pop_desc.mask;
        end else if (adv) begin
            mask_next = rest;
            if (rest == '0) begin
                active_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            active_reg <= active_next;
            if (adv) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            desc_reg <= pop_desc;
        end else begin
            desc_reg.mask <= mask_next;
        end
        if (adv) begin
            x_reg      <= px[9:0];
            y_reg      <= py[9:0];
            colour_reg <= desc_reg.glyph[sel] ? desc_reg.fg : desc_reg.bg;
            last_reg   <= (rest == '0);
        end
    end

    assign m_valid        = out_valid_reg;
    assign m_pixel_x      = x_reg;
    assign m_pixel_y      = y_reg;
    assign m_pixel_colour = colour_reg;
    assign m_last_pixel   = last_reg;

    a_active_mask: assert property (@(posedge aclk) disable iff (!aresetn)
        active_reg |-> (desc_reg.mask != '0))
        else $error("active descriptor has an empty mask");

    a_load_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        load |-> (pop_desc.mask != '0))
        else $error("descriptor with no visible pixel reached the back end");

    a_stay_active: assert property (@(posedge aclk) disable iff (!aresetn)
        (adv && (rest != '0)) |=> active_reg)
        else $error("back end went idle with pixels left");

endmodule

// ----- hw/rtl/glyph_pixel_rasterizer_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Glyph pixel rasterizer
// Draws one 5x7 character per request as a stream of on-screen pixel words.
// ----------------------------------------------------------------------------
// The request passes the front-end register, a queue entry and the back-end
// descriptor register before its first pixel word leaves the output register.
// The back end emits one pixel word per cycle while m_ready allows, one word
// per visible pixel, 1 to 35; one with none is retired by the front end.
// Reset: synchronous active-low aresetn clears all valid and queue state.
// ----------------------------------------------------------------------------
module glyph_pixel_rasterizer_top #(
    parameter int SCREEN_W = 280,
    parameter int SCREEN_H = 240
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic signed [10:0] s_origin_x,
    input  logic signed [10:0] s_origin_y,
    input  logic [7:0]         s_char_code,
    input  logic [15:0]        s_fg_colour,
    input  logic [15:0]        s_bg_colour,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [9:0]         m_pixel_x,
    output logic [9:0]         m_pixel_y,
    output logic [15:0]        m_pixel_colour,
    output logic               m_last_pixel
);
    import gpr_pkg::*;

    logic  push_valid;
    logic  push_ready;
    desc_t push_desc;
    logic  pop_valid;
    logic  pop_ready;
    desc_t pop_desc;

    gpr_front #(
        .SCREEN_W (SCREEN_W),
        .SCREEN_H (SCREEN_H)
    ) u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_origin_x  (s_origin_x),
        .s_origin_y  (s_origin_y),
        .s_char_code (s_char_code),
        .s_fg_colour (s_fg_colour),
        .s_bg_colour (s_bg_colour),
        .push_valid  (push_valid),
        .push_ready  (push_ready),
        .push_desc   (push_desc)
    );

    gpr_fifo u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (push_valid),
        .in_ready  (push_ready),
        .in_desc   (push_desc),
        .out_valid (pop_valid),
        .out_ready (pop_ready),
        .out_desc  (pop_desc)
    );

    gpr_back u_back (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .pop_valid      (pop_valid),
        .pop_ready      (pop_ready),
        .pop_desc       (pop_desc),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_pixel_x      (m_pixel_x),
        .m_pixel_y      (m_pixel_y),
        .m_pixel_colour (m_pixel_colour),
        .m_last_pixel   (m_last_pixel)
    );

endmodule

// ----- tb/sv/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Glyph pixel rasterizer testbench
// Sends character requests into the rasterizer and checks every pixel word
// against a local 5x7 font walker. Both sides idle at random, the receiver
// holds off for one long stretch, and the run ends with a calm drain.
// ----------------------------------------------------------------------------
module testbench;

    localparam int SCREEN_W   = 280;
    localparam int SCREEN_H   = 240;
    localparam int RAND_ITEMS = 450;
    localparam int HOLD_LEN   = 500;
    localparam int DRAIN_LEN  = 40;
    localparam int CYCLE_CAP  = 1_000_000;
    localparam int FIRST_CODE = 32;
    localparam int LAST_CODE  = 90;

    // One 40-bit entry per code from space to 'Z', column 0 in the top byte.
    localparam logic [59*40-1:0] FONT_ROM = {
        40'h0000000000, 40'h00005F0000, 40'h0007000700, 40'h147F147F14,
        40'h242A7F2A12, 40'h2313086462, 40'h3649552250, 40'h0005030000,
        40'h001C224100, 40'h0041221C00, 40'h082A1C2A08, 40'h08083E0808,
        40'h0050300000, 40'h0808080808, 40'h0060600000, 40'h2010080402,
        40'h3E5149453E, 40'h00427F4000, 40'h4261514946, 40'h2141454B31,
        40'h1814127F10, 40'h2745454539, 40'h3C4A494930, 40'h0171090503,
        40'h3649494936, 40'h064949291E, 40'h0036360000, 40'h0056360000,
        40'h0008142241, 40'h1414141414, 40'h4122140800, 40'h0201510906,
        40'h324979413E, 40'h7E1111117E, 40'h7F49494936, 40'h3E41414122,
        40'h7F4141221C, 40'h7F49494941, 40'h7F09090101, 40'h3E41415132,
        40'h7F0808087F, 40'h00417F4100, 40'h2040413F01, 40'h7F08142241,
        40'h7F40404040, 40'h7F0204027F, 40'h7F0408107F, 40'h3E4141413E,
        40'h7F09090906, 40'h3E4151215E, 40'h7F09192946, 40'h4649494931,
        40'h01017F0101, 40'h3F4040403F, 40'h1F2040201F, 40'h7F2018207F,
        40'h6314081463, 40'h0304780403, 40'h6151494543
    };

    typedef struct {
        logic signed [10:0] ox;
        logic signed [10:0] oy;
        logic [7:0]         code;
        logic [15:0]        fg;
        logic [15:0]        bg;
    } char_req_t;

    typedef struct {
        logic [9:0]  x;
        logic [9:0]  y;
        logic [15:0] colour;
        logic        last;
    } pixel_t;

    logic               aclk           = 1'b0;
    logic               aresetn        = 1'b0;
    logic               s_valid        = 1'b0;
    logic               s_ready;
    logic signed [10:0] s_origin_x     = '0;
    logic signed [10:0] s_origin_y     = '0;
    logic [7:0]         s_char_code    = '0;
    logic [15:0]        s_fg_colour    = '0;
    logic [15:0]        s_bg_colour    = '0;
    logic               m_valid;
    logic               m_ready        = 1'b0;
    logic [9:0]         m_pixel_x;
    logic [9:0]         m_pixel_y;
    logic [15:0]        m_pixel_colour;
    logic               m_last_pixel;

    char_req_t char_req_q[$];
    pixel_t    pixel_expect_q[$];
    int        mismatch_count = 0;
    int        send_gap       = 0;
    int        stall_left     = 0;
    int        hold_cycles    = 0;
    int        cycle_count    = 0;
    logic      calm           = 1'b0;
    logic      pressure_go    = 1'b0;
    logic      pressure_done  = 1'b0;
    logic      hold_active    = 1'b0;

    glyph_pixel_rasterizer_top #(
        .SCREEN_W(SCREEN_W),
        .SCREEN_H(SCREEN_H)
    ) u_top (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_origin_x    (s_origin_x),
        .s_origin_y    (s_origin_y),
        .s_char_code   (s_char_code),
        .s_fg_colour   (s_fg_colour),
        .s_bg_colour   (s_bg_colour),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_pixel_x     (m_pixel_x),
        .m_pixel_y     (m_pixel_y),
        .m_pixel_colour(m_pixel_colour),
        .m_last_pixel  (m_last_pixel)
    );

    always #1 aclk = ~aclk;

    task automatic report_mismatch(input string msg);
        $display("mismatch at cycle %0d: %s", cycle_count, msg);
        mismatch_count++;
    endtask

    task automatic rasterize_glyph(input logic signed [10:0] ox, input logic signed [10:0] oy,
                                   input logic [7:0] code, input logic [15:0] fg,
                                   input logic [15:0] bg);
        int          idx;
        int          px;
        int          py;
        int          drawn;
        logic [39:0] cols;
        logic [7:0]  bits;
        pixel_t      pix;
        idx   = 0;
        drawn = 0;
        if (code >= FIRST_CODE && code <= LAST_CODE) begin
            idx = code - FIRST_CODE;
        end
        cols = FONT_ROM[(58 - idx) * 40 +: 40];
        for (int c = 0; c < 5; c++) begin
            bits = cols[(4 - c) * 8 +: 8];
            for (int r = 0; r < 7; r++) begin
                px = ox;
                py = oy;
                px = px + c;
                py = py + r;
                if (bits[r]) begin
                    pix.colour = fg;
                end else if (bg != fg) begin
                    pix.colour = bg;
                end else begin
                    continue;
                end
                if (px < 0 || px >= SCREEN_W || py < 0 || py >= SCREEN_H) begin
                    continue;
                end
                pix.x    = px[9:0];
                pix.y    = py[9:0];
                pix.last = 1'b0;
                pixel_expect_q.push_back(pix);
                drawn++;
            end
        end
        if (drawn > 0) begin
            pixel_expect_q[$].last = 1'b1;
        end
    endtask

    task automatic add_req(input int ox, input int oy, input int code, input int fg,
                           input int bg);
        char_req_t req;
        req.ox   = ox[10:0];
        req.oy   = oy[10:0];
        req.code = code[7:0];
        req.fg   = fg[15:0];
        req.bg   = bg[15:0];
        char_req_q.push_back(req);
    endtask

    function automatic int pick_origin(input int span);
        int pick;
        pick = $urandom_range(0, 9);
        if (pick == 0) begin
            return $signed(11'($urandom_range(0, 2047)));
        end else if (pick == 1) begin
            return $urandom_range(0, 8) - 6;
        end else if (pick == 2) begin
            return span - 6 + $urandom_range(0, 7);
        end
        return $urandom_range(0, span - 5);
    endfunction

    always @(posedge aclk) begin
        char_req_t nxt;
        logic      offer;
        if (!aresetn) begin
            s_valid  <= 1'b0;
            send_gap <= 0;
        end else begin
            if (s_valid && s_ready) begin
                rasterize_glyph(s_origin_x, s_origin_y, s_char_code, s_fg_colour,
                                s_bg_colour);
            end
            if (!s_valid || s_ready) begin
                offer = 1'b0;
                if (send_gap > 0) begin
                    send_gap <= send_gap - 1;
                end else if (char_req_q.size() > 0) begin
                    nxt         = char_req_q.pop_front();
                    offer       = 1'b1;
                    s_origin_x  <= nxt.ox;
                    s_origin_y  <= nxt.oy;
                    s_char_code <= nxt.code;
                    s_fg_colour <= nxt.fg;
                    s_bg_colour <= nxt.bg;
                    if (!calm && $urandom_range(0, 7) == 0) begin
                        send_gap <= $urandom_range(1, 16);
                    end
                end
                s_valid <= offer;
            end
        end
    end

    always @(posedge aclk) begin
        pixel_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pixel_expect_q.size() == 0) begin
                report_mismatch($sformatf("unexpected pixel word x=%0d y=%0d colour=%04h",
                                          m_pixel_x, m_pixel_y, m_pixel_colour));
            end else begin
                want = pixel_expect_q.pop_front();
                if (m_pixel_x !== want.x) begin
                    report_mismatch($sformatf("pixel_x got %0d expected %0d",
                                              m_pixel_x, want.x));
                end
                if (m_pixel_y !== want.y) begin
                    report_mismatch($sformatf("pixel_y got %0d expected %0d",
                                              m_pixel_y, want.y));
                end
                if (m_pixel_colour !== want.colour) begin
                    report_mismatch($sformatf("pixel_colour got %04h expected %04h",
                                              m_pixel_colour, want.colour));
                end
                if (m_last_pixel !== want.last) begin
                    report_mismatch($sformatf("last_pixel got %0b expected %0b",
                                              m_last_pixel, want.last));
                end
            end
        end
        if (!aresetn || hold_active) begin
            m_ready <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            m_ready    <= 1'b0;
        end else if (!calm && $urandom_range(0, 15) == 0) begin
            stall_left <= $urandom_range(0, 15);
            m_ready    <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        if (pressure_go && !pressure_done) begin
            if (hold_cycles == HOLD_LEN - 1) begin
                pressure_done <= 1'b1;
                hold_active   <= 1'b0;
            end else begin
                hold_cycles <= hold_cycles + 1;
                hold_active <= 1'b1;
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_CAP) begin
            $display("glyph_pixel_rasterizer_top test failed");
            $finish;
        end
    end

    initial begin
        int fg;
        int bg;
        int code;
        add_req(0, 0, 32, 16'h1234, 16'h0000);
        add_req(10, 20, 0, 16'hFFFF, 16'h0000);
        add_req(30, 20, 255, 16'h0000, 16'hFFFF);
        add_req(40, 20, 31, 16'hF800, 16'h07E0);
        add_req(50, 20, 91, 16'h001F, 16'hAAAA);
        add_req(60, 20, 126, 16'h5555, 16'h0001);
        add_req(70, 30, 33, 16'hFFFF, 16'h0000);
        add_req(80, 30, 48, 16'hFFFF, 16'h0000);
        add_req(90, 30, 90, 16'hABCD, 16'h1357);
        add_req(100, 30, 65, 16'h7BEF, 16'h7BEF);
        add_req(110, 30, 32, 16'h4321, 16'h4321);
        add_req(-1024, -1024, 72, 16'hFFFF, 16'h0000);
        add_req(1023, 1023, 72, 16'hFFFF, 16'h0000);
        add_req(-2, 50, 87, 16'hC0DE, 16'h0F0F);
        add_req(SCREEN_W - 3, 60, 77, 16'hC0DE, 16'h0F0F);
        add_req(120, -3, 66, 16'h8000, 16'h0001);
        add_req(130, SCREEN_H - 4, 56, 16'h0001, 16'h8000);
        add_req(SCREEN_W - 5, SCREEN_H - 7, 35, 16'hFFFF, 16'hFFFE);
        add_req(SCREEN_W - 1, SCREEN_H - 1, 32, 16'h0F00, 16'h00F0);
        add_req(-5, -7, 64, 16'h1111, 16'h2222);
        add_req(0, 0, 88, 16'h0000, 16'h0000);
        for (int i = 0; i < RAND_ITEMS; i++) begin
            if ($urandom_range(0, 4) == 0) begin
                code = $urandom_range(0, 255);
            end else begin
                code = $urandom_range(FIRST_CODE, LAST_CODE);
            end
            fg = $urandom_range(0, 65535);
            bg = ($urandom_range(0, 4) == 0) ? fg : $urandom_range(0, 65535);
            add_req(pick_origin(SCREEN_W), pick_origin(SCREEN_H), code, fg, bg);
        end

        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        while (char_req_q.size() > 250) @(negedge aclk);
        pressure_go = 1'b1;
        while (char_req_q.size() > 60) @(negedge aclk);
        calm = 1'b1;
        while (char_req_q.size() != 0 || s_valid) @(negedge aclk);
        while (pixel_expect_q.size() != 0) @(negedge aclk);
        repeat (DRAIN_LEN) @(negedge aclk);

        if (mismatch_count == 0) begin
            $display("glyph_pixel_rasterizer_top test passed");
        end else begin
            $display("glyph_pixel_rasterizer_top test failed");
        end
        $finish;
    end

endmodule
